### rtl/u8bt_pkg.sv
package u8bt_pkg;

  localparam int CpW       = 21;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] Lead2Min = 8'hc2;
  localparam logic [7:0] Lead2Max = 8'hdf;
  localparam logic [7:0] Lead4Min = 8'hf0;
  localparam logic [7:0] Lead4Max = 8'hf4;

  localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
  localparam logic [CpW-1:0] SurrLow   = 21'h00d800;
  localparam logic [CpW-1:0] SurrHigh  = 21'h00dfff;
  localparam logic [CpW-1:0] MaxCp     = 21'h10ffff;

  // Continuation-count codes, also the sequence length codes
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_BAD
  } byte_kind_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last_of_text;
  } text_item_t;

  typedef struct packed {
    byte_kind_t kind;
    logic [6:0] bits;
    logic       last;
  } class_item_t;

  typedef struct packed {
    logic           codepoint_done;
    logic [CpW-1:0] codepoint;
    logic           is_whitespace;
    logic           decode_error;
    logic           text_blank;
    logic           end_of_text;
  } result_t;

  // Whitespace ranges of the checker
  function automatic logic is_ws(input logic [CpW-1:0] c);
    logic ws;
    ws = (c >= 21'h000009 && c <= 21'h00000d) ||
         (c >= 21'h00001c && c <= 21'h000020) ||
         (c == 21'h001680) ||
         (c >= 21'h002000 && c <= 21'h002006) ||
         (c >= 21'h002008 && c <= 21'h00200a) ||
         (c >= 21'h002028 && c <= 21'h002029) ||
         (c == 21'h00205f) ||
         (c == 21'h003000);
    return ws;
  endfunction

endpackage

### rtl/u8bt_front.sv
module u8bt_front
  import u8bt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  text_item_t  byte_item,
  output logic        cls_valid,
  output class_item_t cls_item,
  input  logic        cls_pop
);

  class_item_t          cls_in;
  class_item_t          q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  // Classify the incoming byte
  always_comb begin
    cls_in.bits = byte_item.data_byte[6:0];
    cls_in.last = byte_item.last_of_text;
    if (!byte_item.has_byte) begin
      cls_in.kind = KIND_NONE;
    end else if (!byte_item.data_byte[7]) begin
      cls_in.kind = KIND_ASCII;
    end else if (byte_item.data_byte[7:6] == 2'b10) begin
      cls_in.kind = KIND_CONT;
    end else if (byte_item.data_byte >= Lead2Min && byte_item.data_byte <= Lead2Max) begin
      cls_in.kind = KIND_LEAD2;
    end else if (byte_item.data_byte[7:4] == 4'he) begin
      cls_in.kind = KIND_LEAD3;
    end else if (byte_item.data_byte >= Lead4Min && byte_item.data_byte <= Lead4Max) begin
      cls_in.kind = KIND_LEAD4;
    end else begin
      cls_in.kind = KIND_BAD;
    end
  end

  assign full      = (count == QueueCntW'(QueueDepth));
  assign cls_valid = (count != '0);
  assign cls_item  = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cls_pop && cls_valid;

  // Store classified items
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls_in;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/u8bt_back.sv
module u8bt_back
  import u8bt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cls_valid,
  input  class_item_t cls_item,
  output logic        cls_pop,
  output logic        empty,
  input  logic        pop,
  output result_t     result
);

  logic [1:0]     pending, pending_next;
  logic [1:0]     seq_len, seq_len_next;
  logic [CpW-1:0] partial, partial_next;
  logic           still_blank, still_blank_next;
  logic           error_seen, error_seen_next;

  result_t        res;
  logic [CpW-1:0] shifted;
  logic           done;
  logic           err;

  result_t        slot [2];
  logic           head;
  logic [1:0]     out_count;
  logic           out_pop;
  logic           take;

  assign out_pop = pop && (out_count != 2'd0);
  assign take    = cls_valid && ((out_count != 2'd2) || out_pop);
  assign cls_pop = take;
  assign empty   = (out_count == 2'd0);
  assign result  = slot[head];
  assign shifted = {partial[CpW-7:0], cls_item.bits[5:0]};

  // Decode one classified byte
  always_comb begin
    pending_next     = pending;
    seq_len_next     = seq_len;
    partial_next     = partial;
    still_blank_next = still_blank;
    error_seen_next  = error_seen;
    done             = 1'b0;
    err              = 1'b0;
    res              = '0;

    if (cls_item.kind != KIND_NONE && !error_seen) begin
      if (pending == PendNone) begin
        case (cls_item.kind)
          KIND_ASCII: begin
            done          = 1'b1;
            res.codepoint = CpW'(cls_item.bits);
          end
          KIND_LEAD2: begin
            partial_next = CpW'(cls_item.bits[4:0]);
            pending_next = PendOne;
            seq_len_next = PendOne;
          end
          KIND_LEAD3: begin
            partial_next = CpW'(cls_item.bits[3:0]);
            pending_next = PendTwo;
            seq_len_next = PendTwo;
          end
          KIND_LEAD4: begin
            partial_next = CpW'(cls_item.bits[2:0]);
            pending_next = PendThree;
            seq_len_next = PendThree;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end else if (cls_item.kind != KIND_CONT) begin
        err = 1'b1;
      end else begin
        partial_next = shifted;
        pending_next = pending - 2'd1;
        if (pending_next == PendNone) begin
          if ((seq_len == PendTwo && shifted < Min3Byte) ||
              (seq_len == PendThree && shifted < Min4Byte) ||
              (shifted >= SurrLow && shifted <= SurrHigh) ||
              (shifted > MaxCp)) begin
            err = 1'b1;
          end else begin
            done          = 1'b1;
            res.codepoint = shifted;
          end
        end
      end
      if (done) begin
        res.is_whitespace = is_ws(res.codepoint);
        if (!res.is_whitespace) begin
          still_blank_next = 1'b0;
        end
      end
    end

    // Flag a sequence cut short by the end of the text
    if (cls_item.last && !error_seen && !err && pending_next != PendNone) begin
      err = 1'b1;
    end

    if (err) begin
      error_seen_next  = 1'b1;
      still_blank_next = 1'b0;
      pending_next     = PendNone;
      seq_len_next     = PendNone;
      partial_next     = '0;
    end

    res.codepoint_done = done;
    res.decode_error   = err;
    res.text_blank     = cls_item.last && still_blank_next;
    res.end_of_text    = cls_item.last;

    // Return to reset state at the end of a text
    if (cls_item.last) begin
      pending_next     = PendNone;
      seq_len_next     = PendNone;
      partial_next     = '0;
      still_blank_next = 1'b1;
      error_seen_next  = 1'b0;
    end
  end

  // Update decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= PendNone;
      seq_len     <= PendNone;
      partial     <= '0;
      still_blank <= 1'b1;
      error_seen  <= 1'b0;
    end else if (take) begin
      pending     <= pending_next;
      seq_len     <= seq_len_next;
      partial     <= partial_next;
      still_blank <= still_blank_next;
      error_seen  <= error_seen_next;
    end
  end

  // Hold results in a two-entry output buffer
  always_ff @(posedge clk) begin
    if (take) begin
      slot[head ^ out_count[0]] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (out_pop) begin
        head <= ~head;
      end
      if (take && !out_pop) begin
        out_count <= out_count + 2'd1;
      end else if (out_pop && !take) begin
        out_count <= out_count - 2'd1;
      end
    end
  end

endmodule

### rtl/utf8_blank_text_checker_core.sv
// Strict UTF-8 decoder that reports, for every item pushed, one result: the
// code point completed by that byte with its whitespace class, any encoding
// error, and on the last item of a text whether the whole text was blank.
// The block sustains one item per clock while full is low; each item is
// registered first in the classifier queue and then in the decoder's
// output buffer before its result shows. The front classifies bytes into a
// four-entry queue and the decoder keeps a two-entry result buffer, so up
// to six items are taken while results are not being popped before full
// rises. After reset the block is ready at once.
module utf8_blank_text_checker_core
  import u8bt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  text_item_t byte_item,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  logic        cls_valid;
  logic        cls_pop;
  class_item_t cls_item;

  u8bt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .cls_valid (cls_valid),
    .cls_item  (cls_item),
    .cls_pop   (cls_pop)
  );

  u8bt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_item  (cls_item),
    .cls_pop   (cls_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
